// ----- hw/rtl/lbce_pkg.sv -----
// Shared types and constants for the linear block code encoder.
// Holds the request payload structs, command codes and character codes.
// No dependencies; imported by linear_block_code_encoder_top.
package lbce_pkg;

  // Storage limits of the generator matrix and the codeword accumulator.
  localparam int unsigned MaxMsgBits  = 16;
  localparam int unsigned MaxCodeBits = 32;

  // Command codes carried in the input request.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CODE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_MSG_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_TEXT_MODE   = 2'd2;

  // ASCII codes used in text mode.
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_ONE     = 8'd49;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  // Input request payload.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  row_index;
    logic [31:0] row_bits;
    logic [7:0]  data_byte;
  } in_req_t;

  // Output request payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       input_error;
    logic       last;
  } out_req_t;

endpackage

// ----- hw/rtl/linear_block_code_encoder_top.sv -----
// Linear block code encoder: microcoded sequencer, generator row file, output stage.
// Depends on lbce_pkg for payload types, command codes and character codes.
//
// Usage: requests enter on in_valid_i/in_stall_o/in_i and results leave on
// out_valid_o/out_stall_i/out_o. A request is taken when valid is high and
// stall is low. Command 0 writes one generator row, command 1 brings a data
// byte (binary mode) or one character (text mode), command 2 flushes. The
// registers code_length, message_length and text_mode are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while the block is
// idle, and the block itself does not enforce this. A control program in a
// read-only table steps through each request one control word per cycle unless
// the output stalls it, so one request is processed at a time. For each
// codeword, k rows are accumulated one per cycle and n codeword bits are emitted
// one per cycle unless the output stalls, with a newline first in text mode
// once a codeword has already gone out.
// Each result is held back one slot so that the last one of a request can
// be marked; a result reaches the output register when the next result of
// its request is produced or when the request ends.
// When the receiver stalls, the output register holds its result and the
// sequencer waits at the next step that produces or releases a result.
// Reset clears the message, packing and halt state and loads the register
// defaults n = 7, k = 4, binary mode; generator rows must be written first.
module linear_block_code_encoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [5:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lbce_pkg::in_req_t in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lbce_pkg::out_req_t out_o
);
  import lbce_pkg::*;

  // Micro-operations driving the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD_ROW,
    OP_ADD_BIN,
    OP_ADD_TXT,
    OP_TXT_ERR,
    OP_ENC_INIT,
    OP_ENC_STEP,
    OP_EMIT_INIT,
    OP_PUSH_NL,
    OP_EMIT_BIT,
    OP_ENC_DONE,
    OP_PAD,
    OP_CLEAR,
    OP_FINISH
  } op_e;

  // Jump conditions; when false the step counter advances by one.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_FLUSH,
    C_NOT_DATA,
    C_HALT,
    C_TEXT,
    C_MSG_FULL,
    C_BITS_LEFT,
    C_CH_BIT,
    C_MORE_K,
    C_NO_NL,
    C_MORE_N
  } cond_e;

  typedef struct packed {
    op_e        op;
    cond_e      cond;
    logic [4:0] tgt;
  } ctrl_t;

  // Labeled program addresses.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ADD_BIN  = 5'd5;
  localparam logic [4:0] S_CHECK    = 5'd6;
  localparam logic [4:0] S_MORE     = 5'd7;
  localparam logic [4:0] S_DONE     = 5'd8;
  localparam logic [4:0] S_TEXT     = 5'd9;
  localparam logic [4:0] S_TXT_ADD  = 5'd11;
  localparam logic [4:0] S_FLUSH    = 5'd12;
  localparam logic [4:0] S_PAD      = 5'd14;
  localparam logic [4:0] S_CLEAR    = 5'd15;
  localparam logic [4:0] S_ENC      = 5'd16;
  localparam logic [4:0] S_ENC_LOOP = 5'd17;
  localparam logic [4:0] S_EMIT     = 5'd20;
  localparam logic [4:0] S_LAST     = 5'd22;

  // Control program: one control word per step.
  function automatic ctrl_t rom(input logic [4:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:  w = '{OP_ACCEPT,    C_NO_REQ,    S_IDLE};
      5'd1:  w = '{OP_NONE,      C_FLUSH,     S_FLUSH};
      5'd2:  w = '{OP_LOAD_ROW,  C_NOT_DATA,  S_DONE};
      5'd3:  w = '{OP_NONE,      C_HALT,      S_DONE};
      5'd4:  w = '{OP_NONE,      C_TEXT,      S_TEXT};
      5'd5:  w = '{OP_ADD_BIN,   C_NEXT,      S_IDLE};
      5'd6:  w = '{OP_NONE,      C_MSG_FULL,  S_ENC};
      5'd7:  w = '{OP_NONE,      C_BITS_LEFT, S_ADD_BIN};
      5'd8:  w = '{OP_FINISH,    C_ALWAYS,    S_IDLE};
      5'd9:  w = '{OP_NONE,      C_CH_BIT,    S_TXT_ADD};
      5'd10: w = '{OP_TXT_ERR,   C_ALWAYS,    S_DONE};
      5'd11: w = '{OP_ADD_TXT,   C_ALWAYS,    S_CHECK};
      5'd12: w = '{OP_NONE,      C_TEXT,      S_CLEAR};
      5'd13: w = '{OP_NONE,      C_ALWAYS,    S_ENC};
      5'd14: w = '{OP_PAD,       C_NEXT,      S_IDLE};
      5'd15: w = '{OP_CLEAR,     C_ALWAYS,    S_DONE};
      5'd16: w = '{OP_ENC_INIT,  C_NEXT,      S_IDLE};
      5'd17: w = '{OP_ENC_STEP,  C_MORE_K,    S_ENC_LOOP};
      5'd18: w = '{OP_EMIT_INIT, C_NO_NL,     S_EMIT};
      5'd19: w = '{OP_PUSH_NL,   C_NEXT,      S_IDLE};
      5'd20: w = '{OP_EMIT_BIT,  C_MORE_N,    S_EMIT};
      5'd21: w = '{OP_ENC_DONE,  C_FLUSH,     S_PAD};
      5'd22: w = '{OP_NONE,      C_ALWAYS,    S_MORE};
      default: w = '{OP_NONE,    C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  // Configuration registers.
  logic [5:0] code_len_q;
  logic [4:0] msg_len_q;
  logic       text_q;

  // Sequencer and datapath registers.
  logic [4:0]            pc_q, pc_d;
  in_req_t               item_q, item_d;
  logic [3:0]            bitpos_q, bitpos_d;
  logic [MaxMsgBits-1:0] msg_q, msg_d;
  logic [4:0]            mcnt_q, mcnt_d;
  logic [7:0]            pbyte_q, pbyte_d;
  logic [2:0]            pcnt_q, pcnt_d;
  logic                  emitted_q, emitted_d;
  logic                  halt_q, halt_d;
  logic [MaxCodeBits-1:0] acc_q, acc_d;
  logic [5:0]            idx_q, idx_d;
  out_req_t              pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  out_req_t              out_q, out_d;
  logic                  out_v_q, out_v_d;

  // Generator row file.
  logic [MaxCodeBits-1:0] rows_q [MaxMsgBits];
  logic                   row_we;

  ctrl_t      cw;
  logic [4:0] eff_k;
  logic [5:0] eff_n;
  logic       jump;
  logic       push_req;
  out_req_t   push_data;
  logic       send_need;
  logic       out_free;
  logic       hold;
  logic       bin_bit;
  logic       emit_bit;
  logic       is_ws;

  // Effective lengths: zero reads as one, large values saturate.
  always_comb begin
    if (msg_len_q == 5'd0) begin
      eff_k = 5'd1;
    end else if (msg_len_q > 5'(MaxMsgBits)) begin
      eff_k = 5'(MaxMsgBits);
    end else begin
      eff_k = msg_len_q;
    end
    if (code_len_q == 6'd0) begin
      eff_n = 6'd1;
    end else if (code_len_q > 6'(MaxCodeBits)) begin
      eff_n = 6'(MaxCodeBits);
    end else begin
      eff_n = code_len_q;
    end
  end

  assign cw       = rom(pc_q);
  assign out_free = !out_v_q || !out_stall_i;
  assign bin_bit  = item_q.data_byte[3'(3'd7 - bitpos_q[2:0])];
  assign emit_bit = acc_q[idx_q[4:0]];
  assign is_ws    = (item_q.data_byte == CHAR_SPACE) || (item_q.data_byte == CHAR_TAB) ||
                    (item_q.data_byte == CHAR_NEWLINE);

  // Jump condition select.
  always_comb begin
    unique case (cw.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_REQ:    jump = !in_valid_i;
      C_FLUSH:     jump = (item_q.cmd == CMD_FLUSH);
      C_NOT_DATA:  jump = (item_q.cmd != CMD_DATA);
      C_HALT:      jump = halt_q;
      C_TEXT:      jump = text_q;
      C_MSG_FULL:  jump = (mcnt_q >= eff_k);
      C_BITS_LEFT: jump = !text_q && (bitpos_q != 4'd8);
      C_CH_BIT:    jump = (item_q.data_byte == CHAR_ZERO) || (item_q.data_byte == CHAR_ONE);
      C_MORE_K:    jump = (6'(idx_q + 6'd1) < {1'b0, eff_k});
      C_NO_NL:     jump = !(text_q && emitted_q);
      C_MORE_N:    jump = (6'(idx_q + 6'd1) < eff_n);
      default:     jump = 1'b0;
    endcase
  end

  // Result produced by the current step, before the hold-back slot.
  always_comb begin
    push_req  = 1'b0;
    push_data = '0;
    case (cw.op)
      OP_TXT_ERR: begin
        push_req  = !is_ws;
        push_data = '{item_q.data_byte, 1'b1, 1'b0};
      end
      OP_PUSH_NL: begin
        push_req  = 1'b1;
        push_data = '{CHAR_NEWLINE, 1'b0, 1'b0};
      end
      OP_EMIT_BIT: begin
        push_req = text_q || (pcnt_q == 3'd7);
        if (text_q) begin
          push_data = '{CHAR_ZERO | {7'd0, emit_bit}, 1'b0, 1'b0};
        end else begin
          push_data = '{{pbyte_q[6:0], emit_bit}, 1'b0, 1'b0};
        end
      end
      OP_PAD: begin
        push_req  = (pcnt_q != 3'd0);
        push_data = '{pbyte_q << 3'(4'd8 - {1'b0, pcnt_q}), 1'b0, 1'b0};
      end
      default: ;
    endcase
    send_need = pend_v_q && (push_req || (cw.op == OP_FINISH));
    hold      = send_need && !out_free;
  end

  // Datapath next state.
  always_comb begin
    pc_d      = pc_q;
    item_d    = item_q;
    bitpos_d  = bitpos_q;
    msg_d     = msg_q;
    mcnt_d    = mcnt_q;
    pbyte_d   = pbyte_q;
    pcnt_d    = pcnt_q;
    emitted_d = emitted_q;
    halt_d    = halt_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q;
    row_we    = 1'b0;

    // The output register frees when its request is taken.
    if (out_free) begin
      out_v_d = 1'b0;
    end

    if (!hold) begin
      pc_d = jump ? cw.tgt : 5'(pc_q + 5'd1);
      case (cw.op)
        OP_ACCEPT: begin
          if (in_valid_i) begin
            item_d   = in_i;
            bitpos_d = 4'd0;
          end
        end
        OP_LOAD_ROW: row_we = (item_q.cmd == CMD_LOAD);
        OP_ADD_BIN: begin
          if ((mcnt_q < 5'(MaxMsgBits)) && bin_bit) begin
            msg_d[mcnt_q[3:0]] = 1'b1;
          end
          mcnt_d   = 5'(mcnt_q + 5'd1);
          bitpos_d = 4'(bitpos_q + 4'd1);
        end
        OP_ADD_TXT: begin
          if ((mcnt_q < 5'(MaxMsgBits)) && item_q.data_byte[0]) begin
            msg_d[mcnt_q[3:0]] = 1'b1;
          end
          mcnt_d = 5'(mcnt_q + 5'd1);
        end
        OP_TXT_ERR: begin
          if (!is_ws) begin
            halt_d = 1'b1;
          end
        end
        OP_ENC_INIT: begin
          acc_d = '0;
          idx_d = 6'd0;
        end
        OP_ENC_STEP: begin
          if (msg_q[idx_q[3:0]]) begin
            acc_d = acc_q ^ rows_q[idx_q[3:0]];
          end
          idx_d = 6'(idx_q + 6'd1);
        end
        OP_EMIT_INIT: idx_d = 6'd0;
        OP_EMIT_BIT: begin
          if (!text_q) begin
            if (pcnt_q == 3'd7) begin
              pbyte_d = 8'd0;
              pcnt_d  = 3'd0;
            end else begin
              pbyte_d = {pbyte_q[6:0], emit_bit};
              pcnt_d  = 3'(pcnt_q + 3'd1);
            end
          end
          idx_d = 6'(idx_q + 6'd1);
        end
        OP_ENC_DONE: begin
          emitted_d = 1'b1;
          msg_d     = '0;
          mcnt_d    = 5'd0;
        end
        OP_CLEAR: begin
          msg_d     = '0;
          mcnt_d    = 5'd0;
          pbyte_d   = 8'd0;
          pcnt_d    = 3'd0;
          emitted_d = 1'b0;
          halt_d    = 1'b0;
        end
        default: ;
      endcase

      // Hold-back slot: a new result releases the previous one, and the end
      // of a request releases the held result marked as last.
      if (push_req) begin
        pend_d   = push_data;
        pend_v_d = 1'b1;
        if (pend_v_q) begin
          out_d      = pend_q;
          out_d.last = 1'b0;
          out_v_d    = 1'b1;
        end
      end else if (cw.op == OP_FINISH) begin
        pend_v_d = 1'b0;
        if (pend_v_q) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
        end
      end
    end
  end

  // Sequencer, stream state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= S_IDLE;
      msg_q      <= '0;
      mcnt_q     <= 5'd0;
      pbyte_q    <= 8'd0;
      pcnt_q     <= 3'd0;
      emitted_q  <= 1'b0;
      halt_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      code_len_q <= 6'd7;
      msg_len_q  <= 5'd4;
      text_q     <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      msg_q     <= msg_d;
      mcnt_q    <= mcnt_d;
      pbyte_q   <= pbyte_d;
      pcnt_q    <= pcnt_d;
      emitted_q <= emitted_d;
      halt_q    <= halt_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CODE_LENGTH: code_len_q <= cfg_data_i;
          CFG_MSG_LENGTH:  msg_len_q  <= cfg_data_i[4:0];
          CFG_TEXT_MODE:   text_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    bitpos_q <= bitpos_d;
    acc_q    <= acc_d;
    idx_q    <= idx_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  // Generator row file, written by row load requests.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      rows_q[item_q.row_index] <= item_q.row_bits;
    end
  end

  assign in_stall_o  = (pc_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // The step counter stays inside the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= S_LAST)
    else $error("step counter left the control program");

  // Between requests no result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pc_q == S_IDLE) |-> !pend_v_q)
    else $error("held result left over between requests");

  // Between requests the message count stays below the storage limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_IDLE) |-> (mcnt_q < 5'(MaxMsgBits)))
    else $error("message count out of range while idle");

  // An accepted request starts the decode step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (pc_q == 5'd1))
    else $error("accepted request did not start decoding");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for linear_block_code_encoder_top.
// Drives row loads, data and flush requests and checks every output request
// against a built-in GF(2) encoder predictor; depends on lbce_pkg and the RTL.
module tb;
  import lbce_pkg::*;

  // The block ignores command 3; it has no name in the package.
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned RandomReqs   = 310;
  localparam int unsigned MaxReported  = 60;

  logic     clk_i      = 1'b0;
  logic     rst_ni     = 1'b0;
  logic     cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i = CFG_CODE_LENGTH;
  logic [5:0] cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_i       = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_o;

  linear_block_code_encoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Encoder state as the predictor sees it.
  logic [31:0] gen_rows [MaxMsgBits];
  logic [15:0] msg_bits;
  logic [4:0]  msg_cnt;
  logic [7:0]  pack_bits;
  logic [3:0]  pack_cnt;
  logic        cw_emitted;
  logic        halted;
  logic [5:0]  n_reg;
  logic [4:0]  k_reg;
  logic        text_reg;

  out_req_t step_res[$];
  out_req_t coded_out_q[$];
  in_req_t  req_q[$];

  int unsigned reqs_issued    = 0;
  int unsigned reqs_accepted  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_used  = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned cycle_count    = 0;
  bit          no_idle        = 1'b0;

  // Out-of-range lengths are clamped to 1 and to the storage limits.
  function automatic int unsigned eff_code_len();
    if (n_reg == 0) return 1;
    if (n_reg > MaxCodeBits) return MaxCodeBits;
    return n_reg;
  endfunction

  function automatic int unsigned eff_msg_len();
    if (k_reg == 0) return 1;
    if (k_reg > MaxMsgBits) return MaxMsgBits;
    return k_reg;
  endfunction

  // Codeword is the XOR of the generator rows selected by the message bits.
  function automatic logic [31:0] gf2_codeword();
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < eff_msg_len(); i++)
      if (msg_bits[i]) acc ^= gen_rows[i];
    return acc;
  endfunction

  task automatic emit_symbol(input logic [7:0] sym, input logic err);
    out_req_t r;
    r.out_byte    = sym;
    r.input_error = err;
    r.last        = 1'b0;
    step_res.push_back(r);
  endtask

  // Encode the current message and send it out as characters or packed bits.
  task automatic emit_codeword();
    logic [31:0] cw;
    int unsigned n;
    n  = eff_code_len();
    cw = gf2_codeword();
    if (text_reg) begin
      if (cw_emitted) emit_symbol(CHAR_NEWLINE, 1'b0);
      for (int j = 0; j < n; j++) emit_symbol(cw[j] ? CHAR_ONE : CHAR_ZERO, 1'b0);
    end else begin
      for (int j = 0; j < n; j++) begin
        pack_bits = {pack_bits[6:0], cw[j]};
        pack_cnt++;
        if (pack_cnt == 4'd8) begin
          emit_symbol(pack_bits, 1'b0);
          pack_bits = '0;
          pack_cnt  = '0;
        end
      end
    end
    cw_emitted = 1'b1;
    msg_bits   = '0;
    msg_cnt    = '0;
  endtask

  // A message is encoded as soon as its length reaches the current k.
  task automatic push_msg_bit(input logic b);
    if (msg_cnt < MaxMsgBits && b) msg_bits[msg_cnt] = 1'b1;
    msg_cnt++;
    if (msg_cnt >= eff_msg_len()) emit_codeword();
  endtask

  task automatic clear_stream();
    msg_bits   = '0;
    msg_cnt    = '0;
    pack_bits  = '0;
    pack_cnt   = '0;
    cw_emitted = 1'b0;
    halted     = 1'b0;
  endtask

  // Work out the output requests caused by one input request.
  task automatic encoder_step(input in_req_t req);
    out_req_t r;
    step_res.delete();
    case (req.cmd)
      CMD_LOAD: gen_rows[req.row_index] = req.row_bits;
      CMD_DATA: begin
        if (!halted) begin
          if (text_reg) begin
            if (req.data_byte == CHAR_ZERO || req.data_byte == CHAR_ONE) begin
              push_msg_bit(req.data_byte == CHAR_ONE);
            end else if (req.data_byte != CHAR_SPACE && req.data_byte != CHAR_TAB &&
                         req.data_byte != CHAR_NEWLINE) begin
              emit_symbol(req.data_byte, 1'b1);
              halted = 1'b1;
            end
          end else begin
            for (int b = 7; b >= 0; b--) push_msg_bit(req.data_byte[b]);
          end
        end
      end
      CMD_FLUSH: begin
        // Binary flush encodes the padded message and pads the last byte.
        if (!text_reg) begin
          emit_codeword();
          if (pack_cnt != 0) emit_symbol(pack_bits << (4'd8 - pack_cnt), 1'b0);
        end
        clear_stream();
      end
      default: ;
    endcase
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) coded_out_q.push_back(step_res[i]);
  endtask

  // Mostly short gaps, a few long ones, none in steady phases.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit log_failure();
    mismatches++;
    return mismatches <= MaxReported;
  endfunction

  // Request driver: predicts each accepted request, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        encoder_step(in_i);
        reqs_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_i       <= req_q.pop_front();
          in_valid_i <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted output request with the oldest prediction.
  always @(posedge clk_i) begin
    out_req_t want;
    int unsigned len;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (coded_out_q.size() == 0) begin
          if (log_failure())
            $error("unexpected result: out_byte %02h input_error %0b last %0b",
                   out_o.out_byte, out_o.input_error, out_o.last);
        end else begin
          want = coded_out_q.pop_front();
          if (out_o.out_byte !== want.out_byte && log_failure())
            $error("out_byte mismatch: expected %02h, got %02h",
                   want.out_byte, out_o.out_byte);
          if (out_o.input_error !== want.input_error && log_failure())
            $error("input_error mismatch: expected %0b, got %0b",
                   want.input_error, out_o.input_error);
          if (out_o.last !== want.last && log_failure())
            $error("last mismatch: expected %0b, got %0b", want.last, out_o.last);
        end
      end
      // Random stall runs on the result side.
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        len = pick_gap();
        out_stall_i <= (len > 0);
        if (len > 0) stall_left = len - 1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic queue_req(input logic [1:0] cmd, input logic [3:0] idx,
                           input logic [31:0] row, input logic [7:0] ch);
    in_req_t req;
    req.cmd       = cmd;
    req.row_index = idx;
    req.row_bits  = row;
    req.data_byte = ch;
    req_q.push_back(req);
    reqs_issued++;
  endtask

  // Hold the sender until every request is taken and every result is back,
  // then let the block finish any request that gives no result.
  task automatic wait_idle();
    while (reqs_accepted != reqs_issued) @(negedge clk_i);
    while (coded_out_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all three registers while the block is idle.
  task automatic program_code(input logic [5:0] n, input logic [4:0] k, input logic t);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CODE_LENGTH;
    cfg_data_i <= n;
    n_reg = n;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MSG_LENGTH;
    cfg_data_i <= {1'b0, k};
    k_reg = k;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TEXT_MODE;
    cfg_data_i <= {5'b0, t};
    text_reg = t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned r;
    int unsigned random_reqs;
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [5:0]  n;
    logic [4:0]  k;

    n_reg    = 6'd7;
    k_reg    = 5'd4;
    text_reg = 1'b0;
    clear_stream();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed binary part at the reset code: row extremes, byte extremes,
    // the unused command and two flushes of an empty message.
    queue_req(CMD_LOAD, 4'd0, 32'hFFFF_FFFF, 8'($urandom));
    queue_req(CMD_LOAD, 4'd1, $urandom, 8'($urandom));
    queue_req(CMD_LOAD, 4'd2, $urandom, 8'($urandom));
    queue_req(CMD_LOAD, 4'd3, 32'h0000_0000, 8'($urandom));
    queue_req(CMD_LOAD, 4'd15, $urandom, 8'($urandom));
    queue_req(CMD_DATA, 4'($urandom), $urandom, 8'h00);
    queue_req(CMD_DATA, 4'($urandom), $urandom, 8'hFF);
    queue_req(CMD_NOP, 4'($urandom), $urandom, 8'($urandom));
    queue_req(CMD_FLUSH, 4'($urandom), $urandom, 8'($urandom));
    queue_req(CMD_FLUSH, 4'($urandom), $urandom, 8'($urandom));
    wait_idle();

    // Directed text part: blanks are skipped, the second codeword gets a
    // newline, a bad character halts the stream until the flush.
    program_code(6'd8, 5'd3, 1'b1);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ONE);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_SPACE);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ZERO);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_TAB);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ONE);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_NEWLINE);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ZERO);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ONE);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ONE);
    queue_req(CMD_DATA, 4'($urandom), $urandom, 8'h5A);
    queue_req(CMD_DATA, 4'($urandom), $urandom, CHAR_ZERO);
    queue_req(CMD_FLUSH, 4'($urandom), $urandom, 8'($urandom));
    wait_idle();

    // Random phases; the first ones use the length extremes. A phase that ends
    // without a flush carries its partial message into the next setting.
    phase       = 0;
    random_reqs = 0;
    while (random_reqs < RandomReqs) begin
      case (phase)
        0: program_code(6'd32, 5'd16, 1'b0);
        1: program_code(6'd1, 5'd1, 1'b0);
        2: program_code(6'd32, 5'd1, 1'b1);
        3: program_code(6'd0, 5'd0, 1'b0);
        4: program_code(6'd63, 5'd31, 1'b1);
        5: program_code(6'd1, 5'd16, 1'b1);
        default: begin
          n = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 32) : $urandom_range(0, 63));
          k = 5'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(0, 31));
          program_code(n, k, 1'($urandom_range(0, 1)));
        end
      endcase
      no_idle = (phase % 5 == 3);
      if (phase == 0)
        for (int i = 4; i < 15; i++) queue_req(CMD_LOAD, 4'(i), $urandom, 8'($urandom));
      len = $urandom_range(15, 40);
      for (int i = 0; i < len; i++) begin
        r  = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        if (r < 4) begin
          cmd = CMD_LOAD;
        end else if (r < 6) begin
          cmd = CMD_NOP;
        end else if (r < (text_reg ? 11 : 13)) begin
          cmd = CMD_FLUSH;
        end else begin
          cmd = CMD_DATA;
          r   = $urandom_range(0, 99);
          if (text_reg) begin
            // Mostly message characters, some blanks, rarely a bad character.
            if (r < 84) begin
              ch = $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO;
            end else if (r < 97) begin
              case ($urandom_range(0, 2))
                0: ch = CHAR_SPACE;
                1: ch = CHAR_TAB;
                default: ch = CHAR_NEWLINE;
              endcase
            end else begin
              ch = CHAR_ZERO;
              while (ch == CHAR_ZERO || ch == CHAR_ONE || ch == CHAR_SPACE ||
                     ch == CHAR_TAB || ch == CHAR_NEWLINE)
                ch = 8'($urandom_range(0, 255));
            end
          end else if (r < 10) begin
            ch = 8'h00;
          end else if (r < 20) begin
            ch = 8'hFF;
          end
        end
        queue_req(cmd, 4'($urandom_range(0, 15)), $urandom, ch);
      end
      if ($urandom_range(0, 1))
        queue_req(CMD_FLUSH, 4'($urandom), $urandom, 8'($urandom));
      random_reqs += len;
      wait_idle();
      phase++;
    end

    $display("Run covered %0d requests over %0d code settings in both modes;",
             reqs_accepted, settings_used);
    $display("%0d output requests checked, %0d failures.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
